/* design/nirt_pkg.sv */
// shared types, constants and register codes of the infrared frame transmitter
package nirt_pkg;

   localparam int NIRT_TIME_WIDTH     = 16;
   localparam int NIRT_BITS_PER_BYTE  = 8;
   localparam int NIRT_FRAME_BYTES    = 4;
   localparam int NIRT_FRAME_BITS     = NIRT_FRAME_BYTES * NIRT_BITS_PER_BYTE;
   localparam int NIRT_BITPOS_WIDTH   = $clog2(NIRT_FRAME_BITS);
   localparam int NIRT_QUEUE_DEPTH    = 2;
   localparam int NIRT_CSR_INDEX_WIDTH = 4;
   localparam int NIRT_CSR_DATA_WIDTH  = 16;

   localparam logic [NIRT_BITS_PER_BYTE-1:0] NIRT_SIG_FIRST_RESET  = 8'hEE;
   localparam logic [NIRT_BITS_PER_BYTE-1:0] NIRT_SIG_SECOND_RESET = 8'h87;
   localparam logic [NIRT_BITS_PER_BYTE-1:0] NIRT_PAIRING_RESET    = 8'h3E;
   localparam logic [15:0] NIRT_LEADER_MARK_RESET  = 16'd9000;
   localparam logic [15:0] NIRT_LEADER_SPACE_RESET = 16'd4500;
   localparam logic [15:0] NIRT_BIT_MARK_RESET     = 16'd560;
   localparam logic [15:0] NIRT_ONE_SPACE_RESET    = 16'd1680;
   localparam logic [15:0] NIRT_ZERO_SPACE_RESET   = 16'd560;

   // register indexes
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_SIG_FIRST    = 4'd0;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_SIG_SECOND   = 4'd1;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_PAIRING      = 4'd2;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_LEADER_MARK  = 4'd3;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_LEADER_SPACE = 4'd4;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_BIT_MARK     = 4'd5;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_ONE_SPACE    = 4'd6;
   localparam logic [NIRT_CSR_INDEX_WIDTH-1:0] REG_ZERO_SPACE   = 4'd7;

   // segment length slots
   localparam int SEG_LEADER_MARK  = 0;
   localparam int SEG_LEADER_SPACE = 1;
   localparam int SEG_BIT_MARK     = 2;
   localparam int SEG_ONE_SPACE    = 3;
   localparam int SEG_ZERO_SPACE   = 4;
   localparam int SEG_COUNT        = 5;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic [NIRT_BITS_PER_BYTE-1:0] command_byte;
   } req_beat_type;

   typedef struct packed {
      logic ir_active;
      logic busy_res;
      logic frame_done;
   } rsp_beat_type;

   typedef struct packed {
      logic                          start;
      logic [NIRT_BITS_PER_BYTE-1:0] command_byte;
   } nirt_item_type;

   typedef struct packed {
      logic [NIRT_BITS_PER_BYTE-1:0] sig_first;
      logic [NIRT_BITS_PER_BYTE-1:0] sig_second;
      logic [NIRT_BITS_PER_BYTE-1:0] pairing;
   } nirt_bytes_type;

   typedef enum logic [5:0] {
      PH_IDLE       = 6'b000001,
      PH_LEAD_MARK  = 6'b000010,
      PH_LEAD_SPACE = 6'b000100,
      PH_BIT_MARK   = 6'b001000,
      PH_BIT_SPACE  = 6'b010000,
      PH_STOP_MARK  = 6'b100000
   } nirt_phase_type;

endpackage

/* design/nirt_front.sv */
// input queue: takes request beats and classifies them into start and tick items
module nirt_front
   import nirt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_beat_type  req_data,
   output logic          item_valid,
   output nirt_item_type item,
   input  logic          item_take
);

   localparam int PTR_W = $clog2(NIRT_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(NIRT_QUEUE_DEPTH + 1);

   nirt_item_type           slot_ff [NIRT_QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;
   nirt_item_type           classified;

   assign req_full   = (count_ff == CNT_W'(NIRT_QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      classified.start        = (req_data.opcode == OP_START);
      classified.command_byte = req_data.command_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(NIRT_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(NIRT_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* design/nirt_back.sv */
// frame sequencer: one tick per item, results held in a small output queue
module nirt_back
   import nirt_pkg::*;
#(
   parameter int TIME_WIDTH = NIRT_TIME_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  nirt_item_type                         item,
   output logic                                  item_take,
   input  nirt_bytes_type                        frame_bytes,
   input  logic [SEG_COUNT-1:0][TIME_WIDTH-1:0]  seg_len,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output rsp_beat_type                          rsp_data
);

   localparam int PTR_W = $clog2(NIRT_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(NIRT_QUEUE_DEPTH + 1);

   nirt_phase_type                 phase_ff, phase_in, eff_phase;
   logic [TIME_WIDTH-1:0]          tick_ff, tick_in, eff_tick, next_tick, len;
   logic [NIRT_BITPOS_WIDTH-1:0]   bit_ff, bit_in, eff_bit;
   logic [NIRT_FRAME_BITS-1:0]     shift_ff, shift_in, eff_shift;
   logic                           run;
   logic                           mark;
   logic                           seg_end;
   logic                           step;
   rsp_beat_type                   result;

   rsp_beat_type                   slot_ff [NIRT_QUEUE_DEPTH];
   logic [PTR_W-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           out_full;
   logic                           do_pop;

   assign out_full  = (count_ff == CNT_W'(NIRT_QUEUE_DEPTH));
   assign step      = item_valid && !out_full;
   assign item_take = step;

   // state seen by this tick, with a frame loaded when a start arrives in idle
   always_comb begin
      run       = 1'b1;
      eff_phase = phase_ff;
      eff_tick  = tick_ff;
      eff_bit   = bit_ff;
      eff_shift = shift_ff;
      case (phase_ff)
         PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK, PH_BIT_SPACE, PH_STOP_MARK: begin
         end
         default: begin
            run       = item.start;
            eff_phase = PH_LEAD_MARK;
            eff_tick  = '0;
            eff_bit   = '0;
            eff_shift = {frame_bytes.pairing, item.command_byte,
                         frame_bytes.sig_second, frame_bytes.sig_first};
         end
      endcase
   end

   always_comb begin
      case (eff_phase)
         PH_LEAD_MARK:  len = seg_len[SEG_LEADER_MARK];
         PH_LEAD_SPACE: len = seg_len[SEG_LEADER_SPACE];
         PH_BIT_SPACE:  len = eff_shift[0] ? seg_len[SEG_ONE_SPACE] : seg_len[SEG_ZERO_SPACE];
         default:       len = seg_len[SEG_BIT_MARK];
      endcase
      mark      = (eff_phase == PH_LEAD_MARK) || (eff_phase == PH_BIT_MARK)
               || (eff_phase == PH_STOP_MARK);
      next_tick = eff_tick + 1'b1;
      seg_end   = (next_tick >= len) || (next_tick == '0);
   end

   always_comb begin
      phase_in = eff_phase;
      tick_in  = seg_end ? '0 : next_tick;
      bit_in   = eff_bit;
      shift_in = eff_shift;
      result.ir_active  = run && mark;
      result.busy_res   = run;
      result.frame_done = 1'b0;
      if (seg_end) begin
         case (eff_phase)
            PH_LEAD_MARK:  phase_in = PH_LEAD_SPACE;
            PH_LEAD_SPACE: phase_in = PH_BIT_MARK;
            PH_BIT_MARK:   phase_in = PH_BIT_SPACE;
            PH_BIT_SPACE: begin
               shift_in = eff_shift >> 1;
               if (eff_bit == NIRT_BITPOS_WIDTH'(NIRT_FRAME_BITS - 1)) begin
                  bit_in   = '0;
                  phase_in = PH_STOP_MARK;
               end else begin
                  bit_in   = eff_bit + 1'b1;
                  phase_in = PH_BIT_MARK;
               end
            end
            default: begin
               phase_in          = PH_IDLE;
               result.frame_done = run;
            end
         endcase
      end
      if (!run) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
      end
   end

   // result queue
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (step) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(NIRT_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(NIRT_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (step && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !step) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

/* design/nec_ir_frame_transmitter.sv */
// top level of the infrared frame transmitter: register file and the two halves
//
// Usage: every request beat is one tick of the envelope. opcode selects a plain
// tick or a frame start; command_byte is the third frame byte of a start.
// Push a beat while req_full is low; each beat yields exactly one response
// beat (ir_active, busy_res, frame_done), read with rsp_pop while rsp_empty
// is low, in order.
// A start beat is itself the first leader mark tick. A start during a frame
// counts as a plain tick.
// Path: an accepted request beat is stored in the input queue; the sequencer
// takes it from there and writes its response into the result queue.
// Throughput: one beat per cycle, set by the single-tick step of the frame
// sequencer, while neither of the two-entry queues on both sides is full.
// When the receiver stops popping, the result queue fills, the sequencer holds
// and then req_full rises; nothing is dropped.
// Reset: synchronous; both queues empty, the sequencer idle and all registers
// back to their default frame bytes and timings. csr_ready is always high.
// Registers: csr_index 0..7 in list order, other indexes are ignored.
module nec_ir_frame_transmitter
   import nirt_pkg::*;
#(
   parameter int TIME_WIDTH = NIRT_TIME_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  req_beat_type                    req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output rsp_beat_type                    rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [NIRT_CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [NIRT_CSR_DATA_WIDTH-1:0]  csr_wdata
);

   nirt_bytes_type                        bytes_ff;
   logic [SEG_COUNT-1:0][TIME_WIDTH-1:0]  seg_ff;
   logic [TIME_WIDTH-1:0]                 time_value;
   logic                                  csr_write;
   logic                                  item_valid;
   logic                                  item_take;
   nirt_item_type                         item;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign time_value = TIME_WIDTH'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff.sig_first         <= NIRT_SIG_FIRST_RESET;
         bytes_ff.sig_second        <= NIRT_SIG_SECOND_RESET;
         bytes_ff.pairing           <= NIRT_PAIRING_RESET;
         seg_ff[SEG_LEADER_MARK]    <= TIME_WIDTH'(NIRT_LEADER_MARK_RESET);
         seg_ff[SEG_LEADER_SPACE]   <= TIME_WIDTH'(NIRT_LEADER_SPACE_RESET);
         seg_ff[SEG_BIT_MARK]       <= TIME_WIDTH'(NIRT_BIT_MARK_RESET);
         seg_ff[SEG_ONE_SPACE]      <= TIME_WIDTH'(NIRT_ONE_SPACE_RESET);
         seg_ff[SEG_ZERO_SPACE]     <= TIME_WIDTH'(NIRT_ZERO_SPACE_RESET);
      end else if (csr_write) begin
         case (csr_index)
            REG_SIG_FIRST:    bytes_ff.sig_first       <= csr_wdata[NIRT_BITS_PER_BYTE-1:0];
            REG_SIG_SECOND:   bytes_ff.sig_second      <= csr_wdata[NIRT_BITS_PER_BYTE-1:0];
            REG_PAIRING:      bytes_ff.pairing         <= csr_wdata[NIRT_BITS_PER_BYTE-1:0];
            REG_LEADER_MARK:  seg_ff[SEG_LEADER_MARK]  <= time_value;
            REG_LEADER_SPACE: seg_ff[SEG_LEADER_SPACE] <= time_value;
            REG_BIT_MARK:     seg_ff[SEG_BIT_MARK]     <= time_value;
            REG_ONE_SPACE:    seg_ff[SEG_ONE_SPACE]    <= time_value;
            REG_ZERO_SPACE:   seg_ff[SEG_ZERO_SPACE]   <= time_value;
            default: begin
            end
         endcase
      end
   end

   nirt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   nirt_back #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take),
      .frame_bytes (bytes_ff),
      .seg_len     (seg_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the infrared frame transmitter: queue driver, monitor, envelope predictor
module tb_top
   import nirt_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 250;

   typedef enum logic [1:0] {
      ACT_BEAT,
      ACT_CSR,
      ACT_DRAIN
   } action_kind_type;

   typedef struct packed {
      action_kind_type                 kind;
      req_beat_type                    beat;
      logic [NIRT_CSR_INDEX_WIDTH-1:0] index;
      logic [NIRT_CSR_DATA_WIDTH-1:0]  wdata;
      logic [3:0]                      gap;
   } action_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_push  = 1'b0;
   logic                            req_full;
   req_beat_type                    req_data  = '0;
   logic                            rsp_empty;
   logic                            rsp_pop   = 1'b0;
   rsp_beat_type                    rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [NIRT_CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [NIRT_CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   nec_ir_frame_transmitter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   action_type   plan_q[$];
   rsp_beat_type expected_envelope_q[$];

   // predictor state
   logic [15:0]                  cfg_reg [0:7];
   nirt_phase_type               env_phase;
   logic [15:0]                  env_count;
   logic [NIRT_BITPOS_WIDTH-1:0] env_bitpos;
   logic [NIRT_FRAME_BITS-1:0]   env_shift;

   // register values as planned by the stimulus builder
   logic [15:0] plan_cfg [0:7];

   int         beat_total = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         send_style = 0;
   int         recv_style = 0;
   logic [3:0] gap_left   = '0;
   logic       gap_armed  = 1'b0;
   logic [3:0] stall_left = '0;

   function automatic logic [3:0] draw_gap(int style);
      case (style)
         0:       return 4'd0;
         1:       return 4'($urandom_range(0, 13));
         default: return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 13)) : 4'd0;
      endcase
   endfunction

   function automatic void write_register(logic [NIRT_CSR_INDEX_WIDTH-1:0] idx,
                                          logic [NIRT_CSR_DATA_WIDTH-1:0] data);
      if (idx <= REG_PAIRING)
         cfg_reg[idx] = {8'h00, data[7:0]};
      else if (idx <= REG_ZERO_SPACE)
         cfg_reg[idx] = data;
   endfunction

   function automatic rsp_beat_type step_envelope(req_beat_type beat);
      rsp_beat_type answer;
      logic [15:0]  seg_len;
      logic [15:0]  count_next;
      answer = '0;
      if (env_phase == PH_IDLE) begin
         if (beat.opcode != OP_START)
            return answer;
         env_shift  = {cfg_reg[REG_PAIRING][7:0], beat.command_byte,
                       cfg_reg[REG_SIG_SECOND][7:0], cfg_reg[REG_SIG_FIRST][7:0]};
         env_phase  = PH_LEAD_MARK;
         env_count  = '0;
         env_bitpos = '0;
      end
      answer.ir_active = (env_phase == PH_LEAD_MARK) || (env_phase == PH_BIT_MARK)
                      || (env_phase == PH_STOP_MARK);
      answer.busy_res  = 1'b1;
      case (env_phase)
         PH_LEAD_MARK:  seg_len = cfg_reg[REG_LEADER_MARK];
         PH_LEAD_SPACE: seg_len = cfg_reg[REG_LEADER_SPACE];
         PH_BIT_SPACE:  seg_len = env_shift[0] ? cfg_reg[REG_ONE_SPACE] : cfg_reg[REG_ZERO_SPACE];
         default:       seg_len = cfg_reg[REG_BIT_MARK];
      endcase
      count_next = env_count + 16'd1;
      env_count  = count_next;
      if (count_next >= seg_len || count_next == 16'd0) begin
         env_count = '0;
         case (env_phase)
            PH_LEAD_MARK:  env_phase = PH_LEAD_SPACE;
            PH_LEAD_SPACE: env_phase = PH_BIT_MARK;
            PH_BIT_MARK:   env_phase = PH_BIT_SPACE;
            PH_BIT_SPACE: begin
               env_shift = env_shift >> 1;
               if (env_bitpos == NIRT_BITPOS_WIDTH'(NIRT_FRAME_BITS - 1)) begin
                  env_bitpos = '0;
                  env_phase  = PH_STOP_MARK;
               end else begin
                  env_bitpos = env_bitpos + 1'b1;
                  env_phase  = PH_BIT_MARK;
               end
            end
            default: begin
               env_phase         = PH_IDLE;
               answer.frame_done = 1'b1;
            end
         endcase
      end
      return answer;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_ticks();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return 16'd0;
      else if (r < 13)
         return 16'($urandom_range(1, 2));
      else
         return 16'($urandom_range(3, 6));
   endfunction

   function automatic int plan_len(logic [3:0] idx);
      return (plan_cfg[idx] == 16'd0) ? 1 : int'(plan_cfg[idx]);
   endfunction

   function automatic int frame_ticks();
      int one_len;
      int zero_len;
      one_len  = plan_len(REG_ONE_SPACE);
      zero_len = plan_len(REG_ZERO_SPACE);
      return plan_len(REG_LEADER_MARK) + plan_len(REG_LEADER_SPACE)
           + NIRT_FRAME_BITS * (plan_len(REG_BIT_MARK) + ((one_len > zero_len) ? one_len : zero_len))
           + plan_len(REG_BIT_MARK);
   endfunction

   task automatic add_beat(logic op, logic [7:0] cmd);
      action_type act;
      act                   = '0;
      act.kind              = ACT_BEAT;
      act.beat.opcode       = op;
      act.beat.command_byte = cmd;
      act.gap               = draw_gap(send_style);
      plan_q.push_back(act);
      beat_total++;
   endtask

   task automatic add_csr(logic [NIRT_CSR_INDEX_WIDTH-1:0] idx,
                          logic [NIRT_CSR_DATA_WIDTH-1:0] data);
      action_type act;
      act       = '0;
      act.kind  = ACT_CSR;
      act.index = idx;
      act.wdata = data;
      plan_q.push_back(act);
      if (idx <= REG_ZERO_SPACE)
         plan_cfg[idx] = data;
   endtask

   task automatic add_drain();
      action_type act;
      act      = '0;
      act.kind = ACT_DRAIN;
      plan_q.push_back(act);
   endtask

   task automatic add_ticks(int count);
      for (int k = 0; k < count; k++)
         add_beat(OP_TICK, pick_byte());
   endtask

   // start, then enough ticks to finish, with stray starts mixed in
   task automatic add_frame();
      int span;
      add_beat(OP_START, pick_byte());
      span = frame_ticks() + $urandom_range(0, 6);
      for (int k = 0; k < span; k++)
         add_beat(($urandom_range(0, 11) == 0) ? OP_START : OP_TICK, pick_byte());
   endtask

   always @(posedge clock) begin : beat_driver
      logic       push_n;
      logic       csr_n;
      action_type act;
      if (reset) begin
         req_push  <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         push_n = req_push;
         csr_n  = csr_valid;
         if (req_push && !req_full) begin
            expected_envelope_q.push_back(step_envelope(req_data));
            push_n = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_wdata);
            csr_n = 1'b0;
         end
         if (!push_n && !csr_n && plan_q.size() != 0) begin
            act = plan_q[0];
            case (act.kind)
               ACT_BEAT: begin
                  if (!gap_armed) begin
                     gap_left  = act.gap;
                     gap_armed = 1'b1;
                  end
                  if (gap_left != 4'd0) begin
                     gap_left = gap_left - 1'b1;
                  end else begin
                     req_data  <= act.beat;
                     push_n    = 1'b1;
                     gap_armed = 1'b0;
                     void'(plan_q.pop_front());
                  end
               end
               ACT_CSR: begin
                  if (expected_envelope_q.size() == 0) begin
                     csr_index <= act.index;
                     csr_wdata <= act.wdata;
                     csr_n     = 1'b1;
                     void'(plan_q.pop_front());
                  end
               end
               default: begin
                  if (expected_envelope_q.size() == 0)
                     void'(plan_q.pop_front());
               end
            endcase
         end
         req_push  <= push_n;
         csr_valid <= csr_n;
      end
   end

   function automatic void check_field(string name, logic want, logic got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %b actual %b", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : envelope_monitor
      logic         pop_n;
      rsp_beat_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         pop_n = rsp_pop;
         if (rsp_pop && !rsp_empty) begin
            pop_n = 1'b0;
            if (expected_envelope_q.size() == 0) begin
               $display("%0t unexpected beat: expected none actual %b", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_envelope_q.pop_front();
               check_field("ir_active", want.ir_active, rsp_data.ir_active);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("frame_done", want.frame_done, rsp_data.frame_done);
            end
            if ($urandom_range(0, 31) == 0)
               recv_style = $urandom_range(0, 2);
            stall_left = draw_gap(recv_style);
         end
         if (!pop_n) begin
            if (stall_left != 4'd0)
               stall_left = stall_left - 1'b1;
            else
               pop_n = 1'b1;
         end
         rsp_pop <= pop_n;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int random_goal;
      cfg_reg[REG_SIG_FIRST]    = {8'h00, NIRT_SIG_FIRST_RESET};
      cfg_reg[REG_SIG_SECOND]   = {8'h00, NIRT_SIG_SECOND_RESET};
      cfg_reg[REG_PAIRING]      = {8'h00, NIRT_PAIRING_RESET};
      cfg_reg[REG_LEADER_MARK]  = NIRT_LEADER_MARK_RESET;
      cfg_reg[REG_LEADER_SPACE] = NIRT_LEADER_SPACE_RESET;
      cfg_reg[REG_BIT_MARK]     = NIRT_BIT_MARK_RESET;
      cfg_reg[REG_ONE_SPACE]    = NIRT_ONE_SPACE_RESET;
      cfg_reg[REG_ZERO_SPACE]   = NIRT_ZERO_SPACE_RESET;
      for (int r = 0; r < 8; r++)
         plan_cfg[r] = cfg_reg[r];
      env_phase  = PH_IDLE;
      env_count  = '0;
      env_bitpos = '0;
      env_shift  = '0;

      // directed: idle ticks, zero-length segments, byte masking, ignored indexes
      add_beat(OP_TICK, 8'hFF);
      add_beat(OP_TICK, 8'h00);
      add_csr(REG_SIG_FIRST, 16'hFF00);
      add_csr(REG_SIG_SECOND, 16'h00FF);
      add_csr(REG_PAIRING, 16'h005A);
      add_csr(REG_LEADER_MARK, 16'd0);
      add_csr(REG_LEADER_SPACE, 16'd0);
      add_csr(REG_BIT_MARK, 16'd0);
      add_csr(REG_ONE_SPACE, 16'd0);
      add_csr(REG_ZERO_SPACE, 16'd0);
      add_csr(4'hF, 16'hFFFF);
      add_csr(4'h8, 16'h0001);
      add_beat(OP_START, 8'hFF);
      add_beat(OP_START, 8'h00);
      add_ticks(6);
      add_drain();
      add_beat(OP_START, 8'h81);
      add_ticks(6);
      add_csr(REG_ONE_SPACE, 16'd1);
      add_ticks(frame_ticks() + 4);

      // longest segments, then shortened while the frame is on the air
      add_csr(REG_SIG_FIRST, 16'h00FF);
      add_csr(REG_SIG_SECOND, 16'hFFFF);
      add_csr(REG_PAIRING, 16'h00FF);
      add_csr(REG_LEADER_MARK, 16'hFFFF);
      add_csr(REG_LEADER_SPACE, 16'hFFFF);
      add_csr(REG_BIT_MARK, 16'hFFFF);
      add_csr(REG_ONE_SPACE, 16'hFFFF);
      add_csr(REG_ZERO_SPACE, 16'hFFFF);
      add_beat(OP_START, 8'h00);
      add_ticks(20);
      add_beat(OP_START, 8'hFF);
      add_ticks(20);
      add_csr(REG_LEADER_MARK, 16'd2);
      add_csr(REG_LEADER_SPACE, 16'd1);
      add_csr(REG_BIT_MARK, 16'd1);
      add_csr(REG_ONE_SPACE, 16'd2);
      add_csr(REG_ZERO_SPACE, 16'd1);
      add_ticks(frame_ticks() + 4);

      random_goal = beat_total + RANDOM_BEATS;
      while (beat_total < random_goal) begin
         send_style = $urandom_range(0, 2);
         for (int r = 0; r < 8; r++)
            if ($urandom_range(0, 1) == 1)
               add_csr(4'(r), (r <= int'(REG_PAIRING)) ? {8'($urandom), pick_byte()}
                                                       : pick_ticks());
         if ($urandom_range(0, 3) == 0)
            add_csr(4'($urandom_range(8, 15)), 16'($urandom));
         if ($urandom_range(0, 2) == 0)
            add_drain();
         repeat ($urandom_range(1, 3)) begin
            add_frame();
            add_ticks($urandom_range(0, 5));
         end
      end
      add_ticks(frame_ticks() + 4);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (plan_q.size() != 0 || req_push || csr_valid || expected_envelope_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_envelope_q.size() != 0) begin
         $display("%0t %0d beats never arrived", $time, expected_envelope_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
design/nirt_pkg.sv
design/nirt_front.sv
design/nirt_back.sv
design/nec_ir_frame_transmitter.sv
tb/tb_top.sv
